// File: design/ssp_pkg.sv
// Shared types, constants and saturation helpers for the sprite screen projection.
// Depends on nothing; every other file in this folder refers to it by scoped names.
package ssp_pkg;

    localparam int POS_W      = 32;
    localparam int DEN_W      = 32;
    localparam int SCR_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SAT_W      = 80;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAMERA_X      = 3'd0,
        REG_CAMERA_Y      = 3'd1,
        REG_FACING_X      = 3'd2,
        REG_FACING_Y      = 3'd3,
        REG_LENS_X        = 3'd4,
        REG_LENS_Y        = 3'd5,
        REG_SCREEN_WIDTH  = 3'd6,
        REG_SCREEN_HEIGHT = 3'd7
    } t_reg_idx;

    localparam logic signed [POS_W-1:0] RST_CAMERA_X      = 32'sd0;
    localparam logic signed [POS_W-1:0] RST_CAMERA_Y      = 32'sd0;
    localparam logic signed [POS_W-1:0] RST_FACING_X      = 32'sd65536;
    localparam logic signed [POS_W-1:0] RST_FACING_Y      = 32'sd0;
    localparam logic signed [POS_W-1:0] RST_LENS_X        = 32'sd0;
    localparam logic signed [POS_W-1:0] RST_LENS_Y        = 32'sd43253;
    localparam logic [SCR_W-1:0]        RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [SCR_W-1:0]        RST_SCREEN_HEIGHT = 13'd480;

    typedef struct packed {
        logic signed [POS_W-1:0] camera_x;
        logic signed [POS_W-1:0] camera_y;
        logic signed [POS_W-1:0] facing_x;
        logic signed [POS_W-1:0] facing_y;
        logic signed [POS_W-1:0] lens_x;
        logic signed [POS_W-1:0] lens_y;
        logic [SCR_W-1:0]        screen_width;
        logic [SCR_W-1:0]        screen_height;
        logic signed [POS_W-1:0] invdet;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] depth;
        logic                    zero;
        logic                    neg;
    } t_div_tag;

    typedef struct packed {
        logic signed [15:0]      column_center;
        logic [15:0]             sprite_extent;
        logic [SCR_W-1:0]        row_begin;
        logic [SCR_W-1:0]        row_finish;
        logic [14:0]             col_begin;
        logic signed [15:0]      col_finish;
        logic signed [POS_W-1:0] depth;
        logic                    in_front;
        logic                    degenerate;
    } t_result;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        if (v > 80'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -80'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
        if (v > 80'sd32767) begin
            return 16'sh7fff;
        end else if (v < -80'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

// File: design/ssp_cfg.sv
// Configuration registers and the iterative inverse-determinant sequencer.
// Depends on ssp_pkg.
module ssp_cfg #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output ssp_pkg::t_cfg                       o_cfg,
    output logic                                o_busy
);
    localparam int SW    = ssp_pkg::SAT_W;
    localparam int Q_W   = 2 * FRAC_BITS + 1;
    localparam int CNT_W = $clog2(2 * FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(2 * FRAC_BITS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SUB  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic signed [31:0] r_camera_x, r_camera_y, r_facing_x, r_facing_y, r_lens_x, r_lens_y;
    logic [12:0]        r_screen_width, r_screen_height;
    logic signed [63:0] r_pa, r_pb;
    logic [63:0]        r_den, r_rem;
    logic [Q_W-1:0]     r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_det_neg, r_det_zero;
    logic signed [31:0] r_invdet;

    logic signed [63:0] n_det;
    logic [64:0]        n_trial;
    logic               n_ge;
    logic signed [SW-1:0] n_qs;

    assign n_det   = (r_pa >>> FRAC_BITS) - (r_pb >>> FRAC_BITS);
    assign n_trial = {r_rem, (r_cnt == CNT_TOP)};
    assign n_ge    = (n_trial >= {1'b0, r_den});
    assign n_qs    = r_det_neg ? -signed'(SW'(r_quo)) : signed'(SW'(r_quo));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: n_state = S_IDLE;
            S_MUL:  n_state = S_SUB;
            S_SUB:  n_state = S_DIV;
            S_DIV:  n_state = (r_cnt == '0) ? S_FIN : S_DIV;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_MUL;
        endcase
        if (i_cfg_we) begin
            n_state = S_MUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_MUL;
            r_camera_x      <= ssp_pkg::RST_CAMERA_X;
            r_camera_y      <= ssp_pkg::RST_CAMERA_Y;
            r_facing_x      <= ssp_pkg::RST_FACING_X;
            r_facing_y      <= ssp_pkg::RST_FACING_Y;
            r_lens_x        <= ssp_pkg::RST_LENS_X;
            r_lens_y        <= ssp_pkg::RST_LENS_Y;
            r_screen_width  <= ssp_pkg::RST_SCREEN_WIDTH;
            r_screen_height <= ssp_pkg::RST_SCREEN_HEIGHT;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (ssp_pkg::t_reg_idx'(i_cfg_index))
                    ssp_pkg::REG_CAMERA_X:      r_camera_x      <= signed'(i_cfg_data);
                    ssp_pkg::REG_CAMERA_Y:      r_camera_y      <= signed'(i_cfg_data);
                    ssp_pkg::REG_FACING_X:      r_facing_x      <= signed'(i_cfg_data);
                    ssp_pkg::REG_FACING_Y:      r_facing_y      <= signed'(i_cfg_data);
                    ssp_pkg::REG_LENS_X:        r_lens_x        <= signed'(i_cfg_data);
                    ssp_pkg::REG_LENS_Y:        r_lens_y        <= signed'(i_cfg_data);
                    ssp_pkg::REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[12:0];
                    ssp_pkg::REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

    // det = lens x facing, then 2^(2F) / det one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MUL: begin
                r_pa <= r_lens_x * r_facing_y;
                r_pb <= r_facing_x * r_lens_y;
            end
            S_SUB: begin
                r_det_neg  <= n_det[63];
                r_det_zero <= (n_det == '0);
                r_den      <= n_det[63] ? 64'(-n_det) : 64'(n_det);
                r_rem      <= '0;
                r_quo      <= '0;
                r_cnt      <= CNT_TOP;
            end
            S_DIV: begin
                r_rem <= n_ge ? 64'(n_trial - {1'b0, r_den}) : n_trial[63:0];
                r_quo <= {r_quo[Q_W-2:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_FIN: begin
                r_invdet <= r_det_zero ? 32'sd0 : ssp_pkg::sat32(n_qs);
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_cfg.camera_x      = r_camera_x;
        o_cfg.camera_y      = r_camera_y;
        o_cfg.facing_x      = r_facing_x;
        o_cfg.facing_y      = r_facing_y;
        o_cfg.lens_x        = r_lens_x;
        o_cfg.lens_y        = r_lens_y;
        o_cfg.screen_width  = r_screen_width;
        o_cfg.screen_height = r_screen_height;
        o_cfg.invdet        = r_invdet;
    end

endmodule

// File: design/ssp_xform.sv
// Front pipeline: camera offset, inverse camera transform and divider operand set-up.
// Depends on ssp_pkg; feeds ssp_div_pipe.
module ssp_xform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic signed [ssp_pkg::POS_W-1:0]        i_sprite_pos_x,
    input  logic signed [ssp_pkg::POS_W-1:0]        i_sprite_pos_y,
    input  ssp_pkg::t_cfg                           i_cfg,
    output logic                                    o_valid,
    output logic [ssp_pkg::POS_W+FRAC_BITS-1:0]     o_num_q,
    output logic [ssp_pkg::POS_W+FRAC_BITS-1:0]     o_num_e,
    output logic [ssp_pkg::DEN_W-1:0]               o_den,
    output ssp_pkg::t_div_tag                       o_tag
);
    localparam int SW    = ssp_pkg::SAT_W;
    localparam int NUM_W = ssp_pkg::POS_W + FRAC_BITS;

    logic signed [31:0] cx, cy, fx, fy, lx, ly, invdet;
    assign cx     = signed'(i_cfg.camera_x);
    assign cy     = signed'(i_cfg.camera_y);
    assign fx     = signed'(i_cfg.facing_x);
    assign fy     = signed'(i_cfg.facing_y);
    assign lx     = signed'(i_cfg.lens_x);
    assign ly     = signed'(i_cfg.lens_y);
    assign invdet = signed'(i_cfg.invdet);

    logic [5:0] r_valid;

    logic signed [31:0] r_a_sx, r_a_sy;
    logic signed [63:0] r_b_p0, r_b_p1, r_b_p2, r_b_p3;
    logic signed [31:0] r_c_lat, r_c_dep;
    logic signed [63:0] r_d_m0, r_d_m1;
    logic signed [31:0] r_e_lat, r_e_dep;
    logic [NUM_W-1:0]   r_f_num_q, r_f_num_e;
    logic [31:0]        r_f_den;
    ssp_pkg::t_div_tag  r_f_tag;

    logic signed [32:0] n_dx, n_dy;
    logic signed [64:0] n_lat0, n_dep0;
    logic [31:0]        n_mag_lat, n_mag_dep;
    logic               n_zero;

    assign n_dx   = 33'(i_sprite_pos_x) - 33'(cx);
    assign n_dy   = 33'(i_sprite_pos_y) - 33'(cy);
    assign n_lat0 = 65'(r_b_p0 >>> FRAC_BITS) - 65'(r_b_p1 >>> FRAC_BITS);
    assign n_dep0 = 65'(r_b_p2 >>> FRAC_BITS) - 65'(r_b_p3 >>> FRAC_BITS);

    assign n_mag_lat = r_e_lat[31] ? 32'(-(33'(r_e_lat))) : 32'(r_e_lat);
    assign n_mag_dep = r_e_dep[31] ? 32'(-(33'(r_e_dep))) : 32'(r_e_dep);
    assign n_zero    = (r_e_dep == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_sx  <= ssp_pkg::sat32(SW'(n_dx));
            r_a_sy  <= ssp_pkg::sat32(SW'(n_dy));
            r_b_p0  <= fy * r_a_sx;
            r_b_p1  <= fx * r_a_sy;
            r_b_p2  <= lx * r_a_sy;
            r_b_p3  <= ly * r_a_sx;
            r_c_lat <= ssp_pkg::sat32(SW'(n_lat0));
            r_c_dep <= ssp_pkg::sat32(SW'(n_dep0));
            r_d_m0  <= invdet * r_c_lat;
            r_d_m1  <= invdet * r_c_dep;
            r_e_lat <= ssp_pkg::sat32(SW'(r_d_m0 >>> FRAC_BITS));
            r_e_dep <= ssp_pkg::sat32(SW'(r_d_m1 >>> FRAC_BITS));
            r_f_num_q     <= {n_mag_lat, {FRAC_BITS{1'b0}}};
            r_f_num_e     <= NUM_W'({i_cfg.screen_height, {FRAC_BITS{1'b0}}});
            r_f_den       <= n_zero ? 32'd1 : n_mag_dep;
            r_f_tag.depth <= r_e_dep;
            r_f_tag.zero  <= n_zero;
            r_f_tag.neg   <= r_e_lat[31] ^ r_e_dep[31];
        end
    end

    assign o_valid = r_valid[5];
    assign o_num_q = r_f_num_q;
    assign o_num_e = r_f_num_e;
    assign o_den   = r_f_den;
    assign o_tag   = r_f_tag;

endmodule

// File: design/ssp_div_pipe.sv
// Pipelined restoring divider: two numerators over one divisor, one quotient bit a stage.
// Depends on ssp_pkg for the divisor width and the tag that travels alongside.
module ssp_div_pipe #(
    parameter int NUM_W = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [NUM_W-1:0]            i_num_a,
    input  logic [NUM_W-1:0]            i_num_b,
    input  logic [ssp_pkg::DEN_W-1:0]   i_den,
    input  ssp_pkg::t_div_tag           i_tag,
    output logic                        o_valid,
    output logic [NUM_W-1:0]            o_quo_a,
    output logic [NUM_W-1:0]            o_quo_b,
    output ssp_pkg::t_div_tag           o_tag
);
    localparam int DW = ssp_pkg::DEN_W;

    logic              r_valid [NUM_W];
    logic [NUM_W-1:0]  r_num_a [NUM_W];
    logic [NUM_W-1:0]  r_num_b [NUM_W];
    logic [DW-1:0]     r_rem_a [NUM_W];
    logic [DW-1:0]     r_rem_b [NUM_W];
    logic [DW-1:0]     r_den   [NUM_W];
    ssp_pkg::t_div_tag r_tag   [NUM_W];

    logic [NUM_W-1:0]  n_num_a [NUM_W];
    logic [NUM_W-1:0]  n_num_b [NUM_W];
    logic [DW-1:0]     n_rem_a [NUM_W];
    logic [DW-1:0]     n_rem_b [NUM_W];

    // returns {quotient bit, new remainder}
    function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nbit,
                                             input logic [DW-1:0] den);
        logic [DW:0] t;
        t = {rem, nbit};
        if (t >= {1'b0, den}) begin
            return {1'b1, DW'(t - {1'b0, den})};
        end
        return {1'b0, t[DW-1:0]};
    endfunction

    always_comb begin
        logic [NUM_W-1:0] pa, pb;
        logic [DW-1:0]    ra, rb, pd;
        logic [DW:0]      sa, sb;
        for (int s = 0; s < NUM_W; s++) begin
            if (s == 0) begin
                pa = i_num_a;
                pb = i_num_b;
                ra = '0;
                rb = '0;
                pd = i_den;
            end else begin
                pa = r_num_a[s-1];
                pb = r_num_b[s-1];
                ra = r_rem_a[s-1];
                rb = r_rem_b[s-1];
                pd = r_den[s-1];
            end
            sa = div_step(ra, pa[NUM_W-1], pd);
            sb = div_step(rb, pb[NUM_W-1], pd);
            n_num_a[s] = {pa[NUM_W-2:0], sa[DW]};
            n_num_b[s] = {pb[NUM_W-2:0], sb[DW]};
            n_rem_a[s] = sa[DW-1:0];
            n_rem_b[s] = sb[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_W; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s < NUM_W; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
            for (int s = 1; s < NUM_W; s++) begin
                r_den[s] <= r_den[s-1];
                r_tag[s] <= r_tag[s-1];
            end
            for (int s = 0; s < NUM_W; s++) begin
                r_num_a[s] <= n_num_a[s];
                r_num_b[s] <= n_num_b[s];
                r_rem_a[s] <= n_rem_a[s];
                r_rem_b[s] <= n_rem_b[s];
            end
        end
    end

    assign o_valid = r_valid[NUM_W-1];
    assign o_quo_a = r_num_a[NUM_W-1];
    assign o_quo_b = r_num_b[NUM_W-1];
    assign o_tag   = r_tag[NUM_W-1];

endmodule

// File: design/ssp_bounds.sv
// Back pipeline: signed ratio, screen column, extent and clamped draw bounds.
// Depends on ssp_pkg; fed by ssp_div_pipe.
module ssp_bounds #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic [ssp_pkg::POS_W+FRAC_BITS-1:0]     i_quo_q,
    input  logic [ssp_pkg::POS_W+FRAC_BITS-1:0]     i_quo_e,
    input  ssp_pkg::t_div_tag                       i_tag,
    input  ssp_pkg::t_cfg                           i_cfg,
    output logic                                    o_valid,
    output ssp_pkg::t_result                        o_res
);
    localparam int SW     = ssp_pkg::SAT_W;
    localparam int EXT_W  = ssp_pkg::SCR_W + FRAC_BITS;
    localparam int PROD_W = 46;
    localparam int COL_W  = PROD_W - FRAC_BITS;
    localparam int BW     = ((COL_W > EXT_W) ? COL_W : EXT_W) + 2;
    localparam logic signed [32:0]       ONE_Q = 33'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PROD_W-1:0] RND   = PROD_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
    localparam logic signed [BW-1:0]     CB_MAX = BW'(32767);

    logic [3:0] r_valid;

    logic signed [31:0]       r_g_q;
    logic [EXT_W-1:0]         r_g_ext, r_h_ext, r_i_ext;
    logic signed [PROD_W-1:0] r_h_prod;
    logic signed [COL_W-1:0]  r_i_col;
    logic [EXT_W-2:0]         r_i_hext;
    ssp_pkg::t_div_tag        r_g_tag, r_h_tag, r_i_tag;
    ssp_pkg::t_result         r_j_res;

    logic signed [SW-1:0]     n_qs;
    logic signed [32:0]       n_opq;
    logic signed [12:0]       n_hw;
    logic signed [PROD_W-1:0] n_adj;
    logic signed [BW-1:0]     n_col, n_hext, n_hh, n_h, n_w, n_rb, n_rf, n_cb, n_cf, n_cfc;
    ssp_pkg::t_result         n_res;

    assign n_qs  = i_tag.neg ? -signed'(SW'(i_quo_q)) : signed'(SW'(i_quo_q));
    assign n_opq = 33'(r_g_q) + ONE_Q;
    assign n_hw  = signed'({1'b0, i_cfg.screen_width[12:1]});
    assign n_adj = r_h_prod + (r_h_prod[PROD_W-1] ? RND : '0);

    always_comb begin
        n_col  = BW'(r_i_col);
        n_hext = signed'(BW'(r_i_hext));
        n_hh   = signed'(BW'(i_cfg.screen_height[12:1]));
        n_h    = signed'(BW'(i_cfg.screen_height));
        n_w    = signed'(BW'(i_cfg.screen_width));
        n_rb   = n_hh - n_hext;
        n_rf   = n_hext + n_hh;
        n_cb   = n_col - n_hext;
        n_cf   = n_hext + n_col;
        n_cfc  = (n_cf >= n_w) ? n_w : n_cf;

        n_res.column_center = ssp_pkg::sat16(SW'(n_col));
        n_res.sprite_extent = (r_i_ext > EXT_W'(16'hffff)) ? 16'hffff : r_i_ext[15:0];
        n_res.row_begin     = n_rb[BW-1] ? 13'd0 : n_rb[12:0];
        n_res.row_finish    = (n_rf >= n_h) ? i_cfg.screen_height : n_rf[12:0];
        priority if (n_cb[BW-1]) begin
            n_res.col_begin = 15'd0;
        end else if (n_cb > CB_MAX) begin
            n_res.col_begin = 15'h7fff;
        end else begin
            n_res.col_begin = n_cb[14:0];
        end
        n_res.col_finish    = ssp_pkg::sat16(SW'(n_cfc));
        n_res.depth         = r_i_tag.depth;
        n_res.in_front      = !r_i_tag.depth[31] && !r_i_tag.zero;
        n_res.degenerate    = r_i_tag.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g_q    <= i_tag.zero ? 32'sd0 : ssp_pkg::sat32(n_qs);
            r_g_ext  <= i_tag.zero ? '0 : i_quo_e[EXT_W-1:0];
            r_g_tag  <= i_tag;
            r_h_prod <= PROD_W'(n_hw) * PROD_W'(n_opq);
            r_h_ext  <= r_g_ext;
            r_h_tag  <= r_g_tag;
            r_i_col  <= COL_W'(n_adj >>> FRAC_BITS);
            r_i_hext <= r_h_ext[EXT_W-1:1];
            r_i_ext  <= r_h_ext;
            r_i_tag  <= r_h_tag;
            r_j_res  <= n_res;
        end
    end

    assign o_valid = r_valid[3];
    assign o_res   = r_j_res;

endmodule

// File: design/sprite_screen_projection.sv
// Sprite screen projection: top level with output register and skid stage.
// Depends on ssp_pkg, ssp_cfg, ssp_xform, ssp_div_pipe and ssp_bounds.
//
// Input channel: i_valid / o_stall carry one sprite world position per item.
// Output channel: o_valid / i_stall carry the projected column, extent, clamped
// draw bounds, depth and flags for that sprite, in input order.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index at the clock
// edge; write only while no item is in flight.
// Throughput: one item per cycle while o_stall is low. The quotient divider works
// one bit a stage and is 32 + FRAC_BITS stages deep.
// Reset and every configuration write restart the inverse-determinant
// sequencer, a serial divider; o_stall is high until it finishes. Reset
// clears all valid bits and loads the register defaults.
// Receiver stall: the output register holds; one further item lands in the skid
// stage, after which o_stall rises and the whole pipeline freezes.
module sprite_screen_projection #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ssp_pkg::POS_W-1:0]    i_sprite_pos_x,
    input  logic signed [ssp_pkg::POS_W-1:0]    i_sprite_pos_y,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [15:0]                  o_column_center,
    output logic [15:0]                         o_sprite_extent,
    output logic [ssp_pkg::SCR_W-1:0]           o_row_begin,
    output logic [ssp_pkg::SCR_W-1:0]           o_row_finish,
    output logic [14:0]                         o_col_begin,
    output logic signed [15:0]                  o_col_finish,
    output logic signed [ssp_pkg::POS_W-1:0]    o_depth,
    output logic                                o_in_front,
    output logic                                o_degenerate,
    input  logic                                i_cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int NUM_W = ssp_pkg::POS_W + FRAC_BITS;

    ssp_pkg::t_cfg     cfg;
    logic              cfg_busy;
    logic              en;
    logic              xf_valid, dv_valid, bd_valid;
    logic [NUM_W-1:0]  xf_num_q, xf_num_e, dv_quo_q, dv_quo_e;
    logic [ssp_pkg::DEN_W-1:0] xf_den;
    ssp_pkg::t_div_tag xf_tag, dv_tag;
    ssp_pkg::t_result  bd_res;

    logic              r_out_valid, r_skid_valid;
    ssp_pkg::t_result  r_out, r_skid;
    logic              take;

    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid || cfg_busy;
    assign take    = r_out_valid && !i_stall;

    ssp_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_busy      (cfg_busy)
    );

    ssp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_valid && !cfg_busy),
        .i_sprite_pos_x (i_sprite_pos_x),
        .i_sprite_pos_y (i_sprite_pos_y),
        .i_cfg          (cfg),
        .o_valid        (xf_valid),
        .o_num_q        (xf_num_q),
        .o_num_e        (xf_num_e),
        .o_den          (xf_den),
        .o_tag          (xf_tag)
    );

    ssp_div_pipe #(.NUM_W(NUM_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (xf_valid),
        .i_num_a (xf_num_q),
        .i_num_b (xf_num_e),
        .i_den   (xf_den),
        .i_tag   (xf_tag),
        .o_valid (dv_valid),
        .o_quo_a (dv_quo_q),
        .o_quo_b (dv_quo_e),
        .o_tag   (dv_tag)
    );

    ssp_bounds #(.FRAC_BITS(FRAC_BITS)) u_bounds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_valid),
        .i_quo_q (dv_quo_q),
        .i_quo_e (dv_quo_e),
        .i_tag   (dv_tag),
        .i_cfg   (cfg),
        .o_valid (bd_valid),
        .o_res   (bd_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= en && bd_valid;
            end
        end else if (en && bd_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : bd_res;
        end else if (en && bd_valid) begin
            r_skid <= bd_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_column_center = r_out.column_center;
    assign o_sprite_extent = r_out.sprite_extent;
    assign o_row_begin     = r_out.row_begin;
    assign o_row_finish    = r_out.row_finish;
    assign o_col_begin     = r_out.col_begin;
    assign o_col_finish    = r_out.col_finish;
    assign o_depth         = r_out.depth;
    assign o_in_front      = r_out.in_front;
    assign o_degenerate    = r_out.degenerate;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds an item while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid stage filled without a stalled output");

    a_front_not_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_in_front) |-> !o_degenerate)
        else $error("item in front of camera flagged degenerate");

    a_rows_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_row_begin <= o_row_finish))
        else $error("row bounds out of order");

endmodule
